// ----- rtl/ocov_pkg.sv -----
// Package for the online covariance accumulator: payload types, opcodes,
// datapath command types, controller states and the sequencer microcode.
// No dependencies.
`default_nettype none

package ocov_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int SUM_WIDTH   = (COUNT_WIDTH > 32 ? COUNT_WIDTH : 32) + 1;
  localparam int PC_WIDTH    = 6;
  localparam int LOOP_WIDTH  = 7;

  localparam logic [PC_WIDTH-1:0] PC_ADD_DROP = PC_WIDTH'(0);
  localparam logic [PC_WIDTH-1:0] PC_MERGE    = PC_WIDTH'(13);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DROP  = 2'd1,
    OP_MERGE = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e            opcode;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic        [31:0] part_count;
    logic signed [63:0] part_mean_x;
    logic signed [63:0] part_mean_y;
    logic signed [63:0] part_comoment;
  } in_item_t;

  typedef struct packed {
    logic        [31:0] pair_count;
    logic signed [63:0] avg_x;
    logic signed [63:0] avg_y;
    logic signed [63:0] comoment;
    logic               has_data;
    logic               fault;
  } out_item_t;

  typedef enum logic [4:0] {
    DP_IDLE,
    DP_LOAD,
    DP_CLEAR,
    DP_FAULT,
    DP_PREP,
    DP_RESID,
    DP_DIV_LOAD,
    DP_DIV_STEP,
    DP_DIV_STORE,
    DP_MUL_CLEAR,
    DP_MUL_STEP,
    DP_MUL_ACC,
    DP_SHR48,
    DP_SCALE,
    DP_ACC_PART,
    DP_ACC_TERM,
    DP_COMMIT
  } dp_cmd_e;

  typedef enum logic [1:0] {
    DIV_SRC_DX,
    DIV_SRC_DY,
    DIV_SRC_PROD
  } div_src_e;

  typedef enum logic [1:0] {
    DST_MY,
    DST_MX,
    DST_AX,
    DST_AY
  } div_dst_e;

  typedef enum logic [2:0] {
    MUL_DX_E,
    MUL_DX_CNT,
    MUL_DY_CNT,
    MUL_AX_DY,
    MUL_T_PCNT
  } mul_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RUN,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    dp_cmd_e  cmd;
    div_src_e src;
    div_dst_e dst;
    mul_sel_e sel;
    logic     last;
  } uop_t;

  typedef struct packed {
    dp_cmd_e    cmd;
    div_src_e   src;
    div_dst_e   dst;
    mul_sel_e   sel;
    logic [1:0] step;
    logic       out_load;
  } dp_ctrl_t;

  typedef struct packed {
    opcode_e op;
    logic    cnt_zero;
    logic    cnt_one;
    logic    cnt_full;
    logic    merge_ovf;
    logic    merge_zero;
  } dp_stat_t;

  function automatic uop_t mk_uop(dp_cmd_e cmd, div_src_e src, div_dst_e dst,
                                  mul_sel_e sel, logic last);
    uop_t u;
    u.cmd  = cmd;
    u.src  = src;
    u.dst  = dst;
    u.sel  = sel;
    u.last = last;
    return u;
  endfunction

  // add/drop from PC_ADD_DROP, merge from PC_MERGE
  function automatic uop_t ucode(logic [PC_WIDTH-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:    u = mk_uop(DP_DIV_LOAD,  DIV_SRC_DY,   DST_MY, MUL_DX_E,   1'b0);
      6'd1:    u = mk_uop(DP_DIV_STEP,  DIV_SRC_DY,   DST_MY, MUL_DX_E,   1'b0);
      6'd2:    u = mk_uop(DP_DIV_STORE, DIV_SRC_DY,   DST_MY, MUL_DX_E,   1'b0);
      6'd3:    u = mk_uop(DP_DIV_LOAD,  DIV_SRC_DX,   DST_MX, MUL_DX_E,   1'b0);
      6'd4:    u = mk_uop(DP_DIV_STEP,  DIV_SRC_DX,   DST_MX, MUL_DX_E,   1'b0);
      6'd5:    u = mk_uop(DP_DIV_STORE, DIV_SRC_DX,   DST_MX, MUL_DX_E,   1'b0);
      6'd6:    u = mk_uop(DP_RESID,     DIV_SRC_DX,   DST_MY, MUL_DX_E,   1'b0);
      6'd7:    u = mk_uop(DP_MUL_CLEAR, DIV_SRC_DX,   DST_MY, MUL_DX_E,   1'b0);
      6'd8:    u = mk_uop(DP_MUL_STEP,  DIV_SRC_DX,   DST_MY, MUL_DX_E,   1'b0);
      6'd9:    u = mk_uop(DP_MUL_ACC,   DIV_SRC_DX,   DST_MY, MUL_DX_E,   1'b0);
      6'd10:   u = mk_uop(DP_SHR48,     DIV_SRC_DX,   DST_MY, MUL_DX_E,   1'b0);
      6'd11:   u = mk_uop(DP_ACC_TERM,  DIV_SRC_DX,   DST_MY, MUL_DX_E,   1'b0);
      6'd12:   u = mk_uop(DP_COMMIT,    DIV_SRC_DX,   DST_MY, MUL_DX_E,   1'b1);
      6'd13:   u = mk_uop(DP_MUL_CLEAR, DIV_SRC_PROD, DST_AX, MUL_DX_CNT, 1'b0);
      6'd14:   u = mk_uop(DP_MUL_STEP,  DIV_SRC_PROD, DST_AX, MUL_DX_CNT, 1'b0);
      6'd15:   u = mk_uop(DP_MUL_ACC,   DIV_SRC_PROD, DST_AX, MUL_DX_CNT, 1'b0);
      6'd16:   u = mk_uop(DP_DIV_LOAD,  DIV_SRC_PROD, DST_AX, MUL_DX_CNT, 1'b0);
      6'd17:   u = mk_uop(DP_DIV_STEP,  DIV_SRC_PROD, DST_AX, MUL_DX_CNT, 1'b0);
      6'd18:   u = mk_uop(DP_DIV_STORE, DIV_SRC_PROD, DST_AX, MUL_DX_CNT, 1'b0);
      6'd19:   u = mk_uop(DP_MUL_CLEAR, DIV_SRC_PROD, DST_AY, MUL_DY_CNT, 1'b0);
      6'd20:   u = mk_uop(DP_MUL_STEP,  DIV_SRC_PROD, DST_AY, MUL_DY_CNT, 1'b0);
      6'd21:   u = mk_uop(DP_MUL_ACC,   DIV_SRC_PROD, DST_AY, MUL_DY_CNT, 1'b0);
      6'd22:   u = mk_uop(DP_DIV_LOAD,  DIV_SRC_PROD, DST_AY, MUL_DY_CNT, 1'b0);
      6'd23:   u = mk_uop(DP_DIV_STEP,  DIV_SRC_PROD, DST_AY, MUL_DY_CNT, 1'b0);
      6'd24:   u = mk_uop(DP_DIV_STORE, DIV_SRC_PROD, DST_AY, MUL_DY_CNT, 1'b0);
      6'd25:   u = mk_uop(DP_MUL_CLEAR, DIV_SRC_PROD, DST_AY, MUL_AX_DY,  1'b0);
      6'd26:   u = mk_uop(DP_MUL_STEP,  DIV_SRC_PROD, DST_AY, MUL_AX_DY,  1'b0);
      6'd27:   u = mk_uop(DP_MUL_ACC,   DIV_SRC_PROD, DST_AY, MUL_AX_DY,  1'b0);
      6'd28:   u = mk_uop(DP_SHR48,     DIV_SRC_PROD, DST_AY, MUL_AX_DY,  1'b0);
      6'd29:   u = mk_uop(DP_MUL_CLEAR, DIV_SRC_PROD, DST_AY, MUL_T_PCNT, 1'b0);
      6'd30:   u = mk_uop(DP_MUL_STEP,  DIV_SRC_PROD, DST_AY, MUL_T_PCNT, 1'b0);
      6'd31:   u = mk_uop(DP_MUL_ACC,   DIV_SRC_PROD, DST_AY, MUL_T_PCNT, 1'b0);
      6'd32:   u = mk_uop(DP_SCALE,     DIV_SRC_PROD, DST_AY, MUL_T_PCNT, 1'b0);
      6'd33:   u = mk_uop(DP_ACC_PART,  DIV_SRC_PROD, DST_AY, MUL_T_PCNT, 1'b0);
      6'd34:   u = mk_uop(DP_ACC_TERM,  DIV_SRC_PROD, DST_AY, MUL_T_PCNT, 1'b0);
      6'd35:   u = mk_uop(DP_COMMIT,    DIV_SRC_PROD, DST_AY, MUL_T_PCNT, 1'b1);
      default: u = mk_uop(DP_IDLE,      DIV_SRC_DX,   DST_MY, MUL_DX_E,   1'b1);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ocov_ctrl.sv -----
// Controller of the online covariance accumulator: handshake, opcode
// decision and microcode sequencer driving the datapath. Uses ocov_pkg.
`default_nettype none

module ocov_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  ocov_pkg::dp_stat_t  stat_i,
  output ocov_pkg::dp_ctrl_t  ctrl_o
);
  import ocov_pkg::*;

  ctrl_state_e             state_q, state_d;
  logic [PC_WIDTH-1:0]     pc_q, pc_d;
  logic [LOOP_WIDTH-1:0]   ctr_q, ctr_d;
  logic                    out_valid_q, out_valid_d;
  uop_t                    uop;
  dp_cmd_e                 dec_cmd;
  logic                    dec_run;
  logic [PC_WIDTH-1:0]     dec_pc;
  logic                    out_free;

  function automatic logic [LOOP_WIDTH-1:0] loop_len(uop_t u);
    logic [LOOP_WIDTH-1:0] l;
    l = '0;
    if (u.cmd == DP_DIV_STEP) begin
      l = (u.src == DIV_SRC_PROD) ? LOOP_WIDTH'(127) : LOOP_WIDTH'(63);
    end else if (u.cmd == DP_MUL_STEP) begin
      l = LOOP_WIDTH'(3);
    end
    return l;
  endfunction

  assign uop      = ucode(pc_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    dec_cmd = DP_CLEAR;
    dec_run = 1'b0;
    dec_pc  = PC_ADD_DROP;
    unique case (stat_i.op)
      OP_ADD: begin
        if (stat_i.cnt_full) begin
          dec_cmd = DP_FAULT;
        end else begin
          dec_cmd = DP_PREP;
          dec_run = 1'b1;
        end
      end
      OP_DROP: begin
        if (stat_i.cnt_zero) begin
          dec_cmd = DP_FAULT;
        end else if (!stat_i.cnt_one) begin
          dec_cmd = DP_PREP;
          dec_run = 1'b1;
        end
      end
      OP_MERGE: begin
        if (stat_i.merge_ovf) begin
          dec_cmd = DP_FAULT;
        end else if (!stat_i.merge_zero) begin
          dec_cmd = DP_PREP;
          dec_run = 1'b1;
          dec_pc  = PC_MERGE;
        end
      end
      default: dec_cmd = DP_CLEAR;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    ctr_d   = ctr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (dec_run) begin
          state_d = ST_RUN;
          pc_d    = dec_pc;
          ctr_d   = loop_len(ucode(dec_pc));
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_RUN: begin
        if (ctr_q != '0) begin
          ctr_d = ctr_q - LOOP_WIDTH'(1);
        end else if (uop.last) begin
          state_d = ST_OUT;
        end else begin
          pc_d  = pc_q + PC_WIDTH'(1);
          ctr_d = loop_len(ucode(pc_q + PC_WIDTH'(1)));
        end
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o.cmd      = DP_IDLE;
    ctrl_o.src      = uop.src;
    ctrl_o.dst      = uop.dst;
    ctrl_o.sel      = uop.sel;
    ctrl_o.step     = ctr_q[1:0];
    ctrl_o.out_load = 1'b0;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) ctrl_o.cmd = DP_LOAD;
      ST_DECIDE: ctrl_o.cmd = dec_cmd;
      ST_RUN:    ctrl_o.cmd = uop.cmd;
      ST_OUT:    ctrl_o.out_load = out_free;
      default:   ctrl_o.cmd = DP_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && out_stall_i) || ctrl_o.out_load;
  assign out_valid_o = out_valid_q;
  assign in_stall_o  = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ocov_dp.sv -----
// Datapath of the online covariance accumulator: state registers, working
// registers, bit-serial divider, 32x32 multiply-accumulate. Uses ocov_pkg.
`default_nettype none

module ocov_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ocov_pkg::in_item_t  in_item_i,
  input  ocov_pkg::dp_ctrl_t  ctrl_i,
  output ocov_pkg::dp_stat_t  stat_o,
  output ocov_pkg::out_item_t out_item_o
);
  import ocov_pkg::*;

  localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] SMIN = {1'b1, 63'b0};

  function automatic logic [64:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return {1'b1, s[64] ? SMIN : SMAX};
    return {1'b0, s[63:0]};
  endfunction

  function automatic logic [64:0] sat_sub(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return {1'b1, s[64] ? SMIN : SMAX};
    return {1'b0, s[63:0]};
  endfunction

  function automatic logic [64:0] from_mag(logic neg, logic [63:0] m, logic big);
    if (!neg) begin
      if (big || m[63]) return {1'b1, SMAX};
      return {1'b0, m};
    end
    if (big || (m[63] && (m[62:0] != '0))) return {1'b1, SMIN};
    return {1'b0, -m};
  endfunction

  function automatic logic [63:0] mag(logic [63:0] a);
    return a[63] ? -a : a;
  endfunction

  in_item_t               in_q, in_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, n_q, n_d, rem_q, rem_d;
  logic [63:0]            mx_q, mx_d, my_q, my_d, cm_q, cm_d;
  logic [63:0]            dx_q, dx_d, dy_q, dy_d, ax_q, ax_d, t_q, t_d;
  logic [63:0]            nmx_q, nmx_d, nmy_q, nmy_d, cmn_q, cmn_d;
  logic                   flt_q, flt_d;
  logic [127:0]           prod_q, prod_d, dvd_q, dvd_d, pp_wide;
  logic [63:0]            pp_q, pp_d;
  logic [1:0]             ppsh_q, ppsh_d;
  out_item_t              out_q, out_d;

  logic [63:0]            xs, ys, mul_a, mul_b, quo, div_mag;
  logic [31:0]            mul_ai, mul_bi;
  logic                   mul_neg, quo_sgn;
  logic [64:0]            r_quo, r_a, r_b;
  logic [SUM_WIDTH-1:0]   sum;
  logic [COUNT_WIDTH:0]   rem_sh, rem_diff;
  logic                   rem_ge;

  assign xs  = {{16{in_q.x_value[31]}}, in_q.x_value, 16'h0000};
  assign ys  = {{16{in_q.y_value[31]}}, in_q.y_value, 16'h0000};
  assign sum = SUM_WIDTH'(cnt_q) + SUM_WIDTH'(in_q.part_count);

  assign stat_o.op         = in_q.opcode;
  assign stat_o.cnt_zero   = (cnt_q == '0);
  assign stat_o.cnt_one    = (cnt_q == COUNT_WIDTH'(1));
  assign stat_o.cnt_full   = &cnt_q;
  assign stat_o.merge_ovf  = (sum[SUM_WIDTH-1:COUNT_WIDTH] != '0);
  assign stat_o.merge_zero = (sum == '0);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (ctrl_i.sel)
      MUL_DX_E: begin
        mul_a   = mag(dx_q);
        mul_b   = mag(dy_q);
        mul_neg = dx_q[63] ^ dy_q[63];
      end
      MUL_DX_CNT: begin
        mul_a = mag(dx_q);
        mul_b = 64'(cnt_q);
      end
      MUL_DY_CNT: begin
        mul_a = mag(dy_q);
        mul_b = 64'(cnt_q);
      end
      MUL_AX_DY: begin
        mul_a   = mag(ax_q);
        mul_b   = mag(dy_q);
        mul_neg = ax_q[63] ^ dy_q[63];
      end
      MUL_T_PCNT: begin
        mul_a = mag(t_q);
        mul_b = 64'(in_q.part_count);
      end
      default: mul_a = '0;
    endcase
  end

  assign mul_ai = ctrl_i.step[1] ? mul_a[63:32] : mul_a[31:0];
  assign mul_bi = ctrl_i.step[0] ? mul_b[63:32] : mul_b[31:0];

  always_comb begin
    case (ppsh_q)
      2'd0:    pp_wide = {64'b0, pp_q};
      2'd1:    pp_wide = {32'b0, pp_q, 32'b0};
      default: pp_wide = {pp_q, 64'b0};
    endcase
  end

  assign rem_sh   = {rem_q, dvd_q[127]};
  assign rem_diff = rem_sh - {1'b0, n_q};
  assign rem_ge   = (rem_sh >= {1'b0, n_q});

  assign quo_sgn = (ctrl_i.dst == DST_MY || ctrl_i.dst == DST_AY) ? dy_q[63] : dx_q[63];
  assign r_quo   = from_mag(quo_sgn, dvd_q[63:0], dvd_q[127:64] != '0);
  assign quo     = r_quo[63:0];
  assign div_mag = (ctrl_i.src == DIV_SRC_DY) ? mag(dy_q) : mag(dx_q);

  always_comb begin
    in_d   = in_q;
    cnt_d  = cnt_q;
    mx_d   = mx_q;
    my_d   = my_q;
    cm_d   = cm_q;
    n_d    = n_q;
    dx_d   = dx_q;
    dy_d   = dy_q;
    ax_d   = ax_q;
    t_d    = t_q;
    nmx_d  = nmx_q;
    nmy_d  = nmy_q;
    cmn_d  = cmn_q;
    flt_d  = flt_q;
    prod_d = prod_q;
    pp_d   = pp_q;
    ppsh_d = ppsh_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    r_a    = '0;
    r_b    = '0;
    unique case (ctrl_i.cmd)
      DP_LOAD: begin
        in_d  = in_item_i;
        flt_d = 1'b0;
      end
      DP_CLEAR: begin
        cnt_d = '0;
        mx_d  = '0;
        my_d  = '0;
        cm_d  = '0;
        flt_d = 1'b0;
      end
      DP_FAULT: flt_d = 1'b1;
      DP_PREP: begin
        cmn_d = cm_q;
        if (in_q.opcode == OP_MERGE) begin
          n_d  = sum[COUNT_WIDTH-1:0];
          r_a  = sat_sub(mx_q, in_q.part_mean_x);
          r_b  = sat_sub(my_q, in_q.part_mean_y);
        end else begin
          n_d  = (in_q.opcode == OP_DROP) ? cnt_q - COUNT_WIDTH'(1)
                                          : cnt_q + COUNT_WIDTH'(1);
          r_a  = sat_sub(xs, mx_q);
          r_b  = sat_sub(ys, my_q);
        end
        dx_d = r_a[63:0];
        dy_d = r_b[63:0];
      end
      DP_RESID: begin
        r_a  = sat_sub(ys, nmy_q);
        dy_d = r_a[63:0];
      end
      DP_DIV_LOAD: begin
        rem_d = '0;
        dvd_d = (ctrl_i.src == DIV_SRC_PROD) ? prod_q : {div_mag, 64'b0};
      end
      DP_DIV_STEP: begin
        rem_d = rem_ge ? rem_diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
        dvd_d = {dvd_q[126:0], rem_ge};
      end
      DP_DIV_STORE: begin
        case (ctrl_i.dst)
          DST_MY: begin
            r_a   = (in_q.opcode == OP_DROP) ? sat_sub(my_q, quo) : sat_add(my_q, quo);
            nmy_d = r_a[63:0];
          end
          DST_MX: begin
            r_a   = (in_q.opcode == OP_DROP) ? sat_sub(mx_q, quo) : sat_add(mx_q, quo);
            nmx_d = r_a[63:0];
          end
          DST_AX: begin
            r_a   = sat_add(in_q.part_mean_x, quo);
            ax_d  = quo;
            nmx_d = r_a[63:0];
          end
          default: begin
            r_a   = sat_add(in_q.part_mean_y, quo);
            nmy_d = r_a[63:0];
          end
        endcase
      end
      DP_MUL_CLEAR: begin
        prod_d = '0;
        pp_d   = '0;
        ppsh_d = '0;
      end
      DP_MUL_STEP: begin
        prod_d = prod_q + pp_wide;
        pp_d   = 64'(mul_ai) * 64'(mul_bi);
        ppsh_d = {1'b0, ctrl_i.step[1]} + {1'b0, ctrl_i.step[0]};
      end
      DP_MUL_ACC: begin
        prod_d = prod_q + pp_wide;
        pp_d   = '0;
      end
      DP_SHR48: begin
        r_a   = from_mag(mul_neg, prod_q[111:48], prod_q[127:112] != '0);
        t_d   = r_a[63:0];
        flt_d = flt_q | r_a[64];
      end
      DP_SCALE: begin
        r_a   = from_mag(t_q[63], prod_q[63:0], prod_q[127:64] != '0);
        t_d   = r_a[63:0];
        flt_d = flt_q | r_a[64];
      end
      DP_ACC_PART: begin
        r_a   = sat_add(cmn_q, in_q.part_comoment);
        cmn_d = r_a[63:0];
        flt_d = flt_q | r_a[64];
      end
      DP_ACC_TERM: begin
        r_a   = (in_q.opcode == OP_DROP) ? sat_sub(cmn_q, t_q) : sat_add(cmn_q, t_q);
        cmn_d = r_a[63:0];
        flt_d = flt_q | r_a[64];
      end
      DP_COMMIT: begin
        cnt_d = n_q;
        mx_d  = nmx_q;
        my_d  = nmy_q;
        cm_d  = cmn_q;
      end
      default: r_b = '0;
    endcase
  end

  always_comb begin
    out_d = out_q;
    if (ctrl_i.out_load) begin
      out_d.pair_count = 32'(cnt_q);
      out_d.avg_x      = mx_q;
      out_d.avg_y      = my_q;
      out_d.comoment   = cm_q;
      out_d.has_data   = (cnt_q != '0);
      out_d.fault      = flt_q;
    end
  end

  assign out_item_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      mx_q  <= '0;
      my_q  <= '0;
      cm_q  <= '0;
      flt_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      mx_q  <= mx_d;
      my_q  <= my_d;
      cm_q  <= cm_d;
      flt_q <= flt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    n_q    <= n_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    ax_q   <= ax_d;
    t_q    <= t_d;
    nmx_q  <= nmx_d;
    nmy_q  <= nmy_d;
    cmn_q  <= cmn_d;
    prod_q <= prod_d;
    pp_q   <= pp_d;
    ppsh_q <= ppsh_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

// ----- rtl/online_covariance_accumulator.sv -----
// Online covariance accumulator: one item at a time, one result per item.
// Add or drop runs two 64-step bit-serial divides and one 32x32 multiply
// pass; merge runs two 128-step divides and four 32x32 multiply passes;
// clear, a rejected item, or a drop or merge leaving no pairs runs neither.
// A new item can transfer in the cycle after the result loads.
// Reset (async, active low) clears count, means and co-moment to zero.
`default_nettype none

module online_covariance_accumulator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ocov_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ocov_pkg::out_item_t out_item_o
);
  import ocov_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  ocov_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  ocov_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
